### hw/rtl/sla_pkg.sv
// ----------------------------------------------------------------------------
// Semi-Lagrangian advection package
// Shared constants, codes and types for the advection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sla_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 128;

    localparam int IDXW  = 8;
    localparam int VALW  = 32;
    localparam int STEPW = 24;
    localparam int CFGW  = 24;
    localparam int CFGIW = 2;

    // Index widths of the banked stores.
    localparam int CIW = $clog2(MAX_COLS);
    localparam int RIW = $clog2(MAX_ROWS);
    localparam int XHW = $clog2(MAX_COLS / 2 + 1);
    localparam int YHW = $clog2(MAX_ROWS / 2 + 1);
    localparam int SCW = $clog2((MAX_COLS + 1) / 2);
    localparam int SRW = $clog2((MAX_ROWS + 1) / 2);

    localparam logic [1:0] OP_LOAD_SC = 2'd0;
    localparam logic [1:0] OP_LOAD_XV = 2'd1;
    localparam logic [1:0] OP_LOAD_YV = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic [CFGIW-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFGIW-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFGIW-1:0] CFG_STEP_RATIO  = 2'd2;

    localparam logic [IDXW-1:0]  GRID_WIDTH_RST  = 8'd128;
    localparam logic [IDXW-1:0]  GRID_HEIGHT_RST = 8'd128;
    localparam logic [STEPW-1:0] STEP_RATIO_RST  = 24'h010000;

    typedef struct packed {
        logic            valid;
        logic [1:0]      op;
        logic [IDXW-1:0] col;
        logic [IDXW-1:0] row;
        logic [VALW-1:0] value;
        logic            in_rng;
    } t_item;

    typedef struct packed {
        logic [IDXW-1:0] i0;
        logic [IDXW-1:0] j0;
        logic [15:0]     fx;
        logic [15:0]     fy;
    } t_pos;

endpackage

`default_nettype wire

### hw/rtl/sla_trace.sv
// ----------------------------------------------------------------------------
// Advection back-trace
// Velocity stores, face averaging, displacement and clamped source point.
// ----------------------------------------------------------------------------
`default_nettype none

module sla_trace (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire sla_pkg::t_item         i_item,
    input  wire logic [sla_pkg::STEPW-1:0] i_step,
    input  wire logic [sla_pkg::IDXW-1:0]  i_w,
    input  wire logic [sla_pkg::IDXW-1:0]  i_h,
    output sla_pkg::t_item              o_item,
    output sla_pkg::t_pos               o_pos
);
    import sla_pkg::*;

    localparam int XADW   = RIW + XHW;
    localparam int YADW   = YHW + CIW;
    localparam int PRODW  = STEPW + 1 + VALW;
    localparam int DISPW  = PRODW - 16;
    localparam int PW     = DISPW + 2;

    logic [VALW-1:0] mem_xe [2**XADW];
    logic [VALW-1:0] mem_xo [2**XADW];
    logic [VALW-1:0] mem_ye [2**YADW];
    logic [VALW-1:0] mem_yo [2**YADW];

    logic [XADW-1:0] x_waddr, x_raddr_e, x_raddr_o;
    logic [YADW-1:0] y_waddr, y_raddr_e, y_raddr_o;
    logic            x_load, y_load, in_rng;
    logic [IDXW:0]   col_p1, row_p1;

    logic [VALW-1:0] r_xa, r_xb, r_ya, r_yb;
    t_item           r_s1, r_s2, r_s3, r_s4;
    t_item           n_s1;
    logic [VALW-1:0] r_avg_x, r_avg_y;
    logic [DISPW-1:0] r_disp_x, r_disp_y;
    t_pos            r_pos;

    logic signed [VALW:0]    sum_x, sum_y;
    logic signed [PRODW-1:0] prod_x, prod_y;
    logic signed [PW-1:0]    px, py, hi_x, hi_y, cx, cy;

    localparam logic signed [PW-1:0] LO_LIM  = PW'(32'h8000);
    localparam logic signed [PW-1:0] HI_OFFS = PW'(32'h18000);

    always_comb begin
        col_p1    = {1'b0, i_item.col} + 1'b1;
        row_p1    = {1'b0, i_item.row} + 1'b1;
        x_load    = i_en && i_item.valid && (i_item.op == OP_LOAD_XV)
                    && (int'(i_item.col) <= MAX_COLS) && (int'(i_item.row) < MAX_ROWS);
        y_load    = i_en && i_item.valid && (i_item.op == OP_LOAD_YV)
                    && (int'(i_item.col) < MAX_COLS) && (int'(i_item.row) <= MAX_ROWS);
        x_waddr   = {RIW'(i_item.row), XHW'(i_item.col >> 1)};
        y_waddr   = {YHW'(i_item.row >> 1), CIW'(i_item.col)};
        // The even bank always holds the face at (index + 1) / 2, the odd
        // bank the one at index / 2, whatever the parity of the cell.
        x_raddr_e = {RIW'(i_item.row), XHW'(col_p1 >> 1)};
        x_raddr_o = {RIW'(i_item.row), XHW'(i_item.col >> 1)};
        y_raddr_e = {YHW'(row_p1 >> 1), CIW'(i_item.col)};
        y_raddr_o = {YHW'(i_item.row >> 1), CIW'(i_item.col)};
        in_rng    = (i_item.col != '0) && ({1'b0, i_item.col} < ({1'b0, i_w} - 1'b1))
                    && (i_item.row != '0) && ({1'b0, i_item.row} < ({1'b0, i_h} - 1'b1));
        n_s1        = i_item;
        n_s1.in_rng = in_rng;
    end

    always_ff @(posedge i_clk) begin
        if (x_load && !i_item.col[0]) begin
            mem_xe[x_waddr] <= i_item.value;
        end
        if (x_load && i_item.col[0]) begin
            mem_xo[x_waddr] <= i_item.value;
        end
        if (y_load && !i_item.row[0]) begin
            mem_ye[y_waddr] <= i_item.value;
        end
        if (y_load && i_item.row[0]) begin
            mem_yo[y_waddr] <= i_item.value;
        end
        if (i_en) begin
            r_xa <= mem_xe[x_raddr_e];
            r_xb <= mem_xo[x_raddr_o];
            r_ya <= mem_ye[y_raddr_e];
            r_yb <= mem_yo[y_raddr_o];
        end
    end

    always_comb begin
        sum_x  = $signed({r_xa[VALW-1], r_xa}) + $signed({r_xb[VALW-1], r_xb});
        sum_y  = $signed({r_ya[VALW-1], r_ya}) + $signed({r_yb[VALW-1], r_yb});
        prod_x = $signed({1'b0, i_step}) * $signed(r_avg_x);
        prod_y = $signed({1'b0, i_step}) * $signed(r_avg_y);
        px     = $signed(PW'({r_s3.col, 16'h0000})) - PW'($signed(r_disp_x));
        py     = $signed(PW'({r_s3.row, 16'h0000})) - PW'($signed(r_disp_y));
        hi_x   = $signed(PW'({i_w, 16'h0000})) - HI_OFFS;
        hi_y   = $signed(PW'({i_h, 16'h0000})) - HI_OFFS;
        cx     = (px < LO_LIM) ? LO_LIM : ((px > hi_x) ? hi_x : px);
        cy     = (py < LO_LIM) ? LO_LIM : ((py > hi_y) ? hi_y : py);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_avg_x  <= VALW'(sum_x >>> 1);
            r_avg_y  <= VALW'(sum_y >>> 1);
            r_disp_x <= DISPW'(prod_x >>> 16);
            r_disp_y <= DISPW'(prod_y >>> 16);
            r_pos.i0 <= cx[16 +: IDXW];
            r_pos.j0 <= cy[16 +: IDXW];
            r_pos.fx <= cx[15:0];
            r_pos.fy <= cy[15:0];
        end
    end

    assign o_item = r_s4;
    assign o_pos  = r_pos;

endmodule

`default_nettype wire

### hw/rtl/sla_blend.sv
// ----------------------------------------------------------------------------
// Advection bilinear blend
// Scalar store in four parity banks, corner weights, products and sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sla_blend (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire sla_pkg::t_item        i_item,
    input  wire sla_pkg::t_pos         i_pos,
    output logic                       o_valid,
    output logic [sla_pkg::VALW-1:0]   o_result_value,
    output logic                       o_in_range,
    output logic [sla_pkg::IDXW-1:0]   o_out_col,
    output logic [sla_pkg::IDXW-1:0]   o_out_row
);
    import sla_pkg::*;

    localparam int SADW = SRW + SCW;
    localparam int WW   = 33;
    localparam int MW   = WW + 1 + VALW;
    localparam int AW   = MW + 2;

    logic [VALW-1:0] mem_sc [4][2**SADW];

    logic            sc_load;
    logic [1:0]      sc_wbank;
    logic [SADW-1:0] sc_waddr;
    logic [SADW-1:0] sc_raddr [4];
    logic [IDXW:0]   i0_p1, j0_p1;
    logic [16:0]     wx0, wy0, wx1, wy1;
    logic signed [AW-1:0] acc;

    t_item           r_s5, r_s6;
    logic [VALW-1:0] r_bank [4];
    logic [WW-1:0]   r_wt [4];
    logic [1:0]      r_par;
    logic signed [MW-1:0] r_prod [4];
    logic            r_out_valid;
    logic [VALW-1:0] r_out_value;
    logic            r_out_rng;
    logic [IDXW-1:0] r_out_col, r_out_row;

    always_comb begin
        sc_load  = i_en && i_item.valid && (i_item.op == OP_LOAD_SC)
                   && (int'(i_item.col) < MAX_COLS) && (int'(i_item.row) < MAX_ROWS);
        sc_wbank = {i_item.row[0], i_item.col[0]};
        sc_waddr = {SRW'(i_item.row >> 1), SCW'(i_item.col >> 1)};
        i0_p1    = {1'b0, i_pos.i0} + 1'b1;
        j0_p1    = {1'b0, i_pos.j0} + 1'b1;
        for (int b = 0; b < 4; b++) begin
            sc_raddr[b] = {(b[1] ? SRW'(i_pos.j0 >> 1) : SRW'(j0_p1 >> 1)),
                           (b[0] ? SCW'(i_pos.i0 >> 1) : SCW'(i0_p1 >> 1))};
        end
        wx1 = {1'b0, i_pos.fx};
        wy1 = {1'b0, i_pos.fy};
        wx0 = 17'h10000 - wx1;
        wy0 = 17'h10000 - wy1;
    end

    always_ff @(posedge i_clk) begin
        if (sc_load) begin
            mem_sc[sc_wbank][sc_waddr] <= i_item.value;
        end
        if (i_en) begin
            for (int b = 0; b < 4; b++) begin
                r_bank[b] <= mem_sc[b][sc_raddr[b]];
            end
        end
    end

    // Corner c is {dy, dx}; it sits in bank c xor the parity of (i0, j0).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wt[0] <= WW'(wx0) * WW'(wy0);
            r_wt[1] <= WW'(wx1) * WW'(wy0);
            r_wt[2] <= WW'(wx0) * WW'(wy1);
            r_wt[3] <= WW'(wx1) * WW'(wy1);
            r_par   <= {i_pos.j0[0], i_pos.i0[0]};
            for (int c = 0; c < 4; c++) begin
                r_prod[c] <= $signed({1'b0, r_wt[c]})
                             * $signed(r_bank[2'(c) ^ r_par]);
            end
        end
    end

    always_comb begin
        acc = AW'(r_prod[0]) + AW'(r_prod[1]) + AW'(r_prod[2]) + AW'(r_prod[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.valid  <= 1'b0;
            r_s6.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s5        <= i_item;
            r_s6        <= r_s5;
            r_out_valid <= r_s6.valid && (r_s6.op == OP_COMPUTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_value <= r_s6.in_rng ? acc[32 +: VALW] : '0;
            r_out_rng   <= r_s6.in_rng;
            r_out_col   <= r_s6.col;
            r_out_row   <= r_s6.row;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_in_range     = r_out_rng;
    assign o_out_col      = r_out_col;
    assign o_out_row      = r_out_row;

endmodule

`default_nettype wire

### hw/rtl/scalar_semi_lagrangian_advect_unit.sv
// ----------------------------------------------------------------------------
// Scalar semi-Lagrangian advection unit
// Loads cell scalars and face velocities, then advects one cell per beat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_op, i_col, i_row, i_value
//  result    out        o_valid / i_stall  o_result_value, o_in_range,
//                                          o_out_col, o_out_row
//  config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One beat is taken every cycle while o_stall is low; a compute result passes
// seven register stages before it shows on the output.
// The depth is set by the velocity store read, the face average, the step
// multiply, the clamp, the scalar bank read, the blend multiplies and the sum.
// A stall on the result side freezes the whole pipeline only while the
// output register holds a result. Reset clears the valid bits and the
// configuration registers; the stores keep their contents until written.
`default_nettype none

module scalar_semi_lagrangian_advect_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_op,
    input  wire logic [sla_pkg::IDXW-1:0]    i_col,
    input  wire logic [sla_pkg::IDXW-1:0]    i_row,
    input  wire logic [sla_pkg::VALW-1:0]    i_value,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [sla_pkg::VALW-1:0]         o_result_value,
    output logic                             o_in_range,
    output logic [sla_pkg::IDXW-1:0]         o_out_col,
    output logic [sla_pkg::IDXW-1:0]         o_out_row,
    input  wire logic                        i_cfg_we,
    input  wire logic [sla_pkg::CFGIW-1:0]   i_cfg_idx,
    input  wire logic [sla_pkg::CFGW-1:0]    i_cfg_data
);
    import sla_pkg::*;

    logic [IDXW-1:0]  r_grid_width, r_grid_height;
    logic [STEPW-1:0] r_step_ratio;
    logic [IDXW-1:0]  w_eff, h_eff;
    logic             en;
    t_item            in_item, tr_item;
    t_pos             tr_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_step_ratio  <= STEP_RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[IDXW-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[IDXW-1:0];
                CFG_STEP_RATIO:  r_step_ratio  <= i_cfg_data[STEPW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_width < IDXW'(3)) begin
            w_eff = IDXW'(3);
        end else if (int'(r_grid_width) > MAX_COLS) begin
            w_eff = IDXW'(MAX_COLS);
        end else begin
            w_eff = r_grid_width;
        end
        if (r_grid_height < IDXW'(3)) begin
            h_eff = IDXW'(3);
        end else if (int'(r_grid_height) > MAX_ROWS) begin
            h_eff = IDXW'(MAX_ROWS);
        end else begin
            h_eff = r_grid_height;
        end
        en             = !(o_valid && i_stall);
        in_item.valid  = i_valid;
        in_item.op     = i_op;
        in_item.col    = i_col;
        in_item.row    = i_row;
        in_item.value  = i_value;
        in_item.in_rng = 1'b0;
    end

    assign o_stall = !en;

    sla_trace u_trace (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (in_item),
        .i_step  (r_step_ratio),
        .i_w     (w_eff),
        .i_h     (h_eff),
        .o_item  (tr_item),
        .o_pos   (tr_pos)
    );

    sla_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_item         (tr_item),
        .i_pos          (tr_pos),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_in_range     (o_in_range),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row)
    );

endmodule

`default_nettype wire

### hw/rtl/sla_check.sv
// ----------------------------------------------------------------------------
// Advection unit port checker
// Port-level properties of the advection unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sla_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_result_value,
    input wire logic        o_in_range,
    input wire logic [7:0]  o_out_col,
    input wire logic [7:0]  o_out_row
);

    // A waiting result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value))
        else $error("result changed while stalled");

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_range |-> o_result_value == 32'd0)
        else $error("border cell gave a non-zero result");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_range |-> o_out_col != 8'd0 && o_out_row != 8'd0)
        else $error("interior flag on a border cell");

    // The input side is only held back by a result that is not taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

bind scalar_semi_lagrangian_advect_unit sla_check u_sla_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_value (o_result_value),
    .o_in_range     (o_in_range),
    .o_out_col      (o_out_col),
    .o_out_row      (o_out_row)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Advection unit testbench
// Drives load and compute beats with random gaps and result-side stalls,
// predicts each compute result from a local copy of the stores and the
// configuration, and checks every result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import sla_pkg::*;

    localparam logic [CFGIW-1:0] CFG_UNUSED = 2'd3;
    localparam int XV_STRIDE = MAX_COLS + 1;
    localparam int LATENCY_WAIT = 20;

    typedef struct packed {
        logic [VALW-1:0] value;
        logic            in_range;
        logic [IDXW-1:0] col;
        logic [IDXW-1:0] row;
    } t_advect_res;

    typedef struct {
        logic [1:0]      op;
        int unsigned     col;
        int unsigned     row;
        logic [VALW-1:0] value;
        bit              typed;
        logic [VALW-1:0] exp_value;
    } t_dir_row;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall;
    logic [1:0] i_op;
    logic [IDXW-1:0] i_col, i_row;
    logic [VALW-1:0] i_value;
    logic o_valid, i_stall;
    logic [VALW-1:0] o_result_value;
    logic o_in_range;
    logic [IDXW-1:0] o_out_col, o_out_row;
    logic i_cfg_we;
    logic [CFGIW-1:0] i_cfg_idx;
    logic [CFGW-1:0] i_cfg_data;

    scalar_semi_lagrangian_advect_unit dut (.*);

    // Local copy of the block's state
    logic [31:0] scalar_mem [MAX_COLS*MAX_ROWS];
    logic [31:0] xvel_mem [XV_STRIDE*MAX_ROWS];
    logic [31:0] yvel_mem [MAX_COLS*(MAX_ROWS+1)];
    bit scalar_set [MAX_COLS*MAX_ROWS];
    bit xvel_set [XV_STRIDE*MAX_ROWS];
    bit yvel_set [MAX_COLS*(MAX_ROWS+1)];
    logic [7:0] grid_w, grid_h;
    logic [23:0] step_r;

    t_advect_res pending_results[$];
    int mismatches;
    int beats_sent;
    bit tx_quiet, rx_quiet, rx_hold_req;

    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = 1'b1;
            #6 i_clk = 1'b0;
        end
    end

    initial begin
        #(12 * 1000000);
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned eff_size(logic [7:0] n);
        if (n < 3) return 3;
        if (n > MAX_COLS) return MAX_COLS;
        return n;
    endfunction

    function automatic longint trace_axis_q(int unsigned idx, logic [31:0] fa,
                                            logic [31:0] fb, int unsigned size);
        longint avg, disp, p, hi;
        avg = (longint'(signed'(fa)) + longint'(signed'(fb))) >>> 1;
        disp = (longint'(step_r) * avg) >>> 16;
        p = (longint'(idx) <<< 16) - disp;
        hi = (longint'(size) <<< 16) - 64'sh18000;
        if (p < 64'sh8000) p = 64'sh8000;
        if (p > hi) p = hi;
        return p;
    endfunction

    function automatic bit cell_interior(int unsigned c, int unsigned r);
        return c >= 1 && c < eff_size(grid_w) - 1 && r >= 1 && r < eff_size(grid_h) - 1;
    endfunction

    function automatic void source_point(int unsigned c, int unsigned r,
                                         output int unsigned i0, output int unsigned j0,
                                         output longint fx, output longint fy);
        longint sx, sy;
        sx = trace_axis_q(c, xvel_mem[r*XV_STRIDE + c], xvel_mem[r*XV_STRIDE + c + 1],
                          eff_size(grid_w));
        sy = trace_axis_q(r, yvel_mem[r*MAX_COLS + c], yvel_mem[(r+1)*MAX_COLS + c],
                          eff_size(grid_h));
        i0 = 32'(sx >>> 16);
        j0 = 32'(sy >>> 16);
        fx = sx & 64'hFFFF;
        fy = sy & 64'hFFFF;
    endfunction

    function automatic t_advect_res advect_cell(int unsigned c, int unsigned r);
        t_advect_res res;
        int unsigned i0, j0;
        longint fx, fy, wx0, wy0, acc;
        res.col = IDXW'(c);
        res.row = IDXW'(r);
        res.value = '0;
        res.in_range = 1'b0;
        if (!cell_interior(c, r)) return res;
        source_point(c, r, i0, j0, fx, fy);
        wx0 = 64'sh10000 - fx;
        wy0 = 64'sh10000 - fy;
        acc = (wx0 * wy0) * longint'(signed'(scalar_mem[j0*MAX_COLS + i0]));
        acc += (wx0 * fy) * longint'(signed'(scalar_mem[(j0+1)*MAX_COLS + i0]));
        acc += (fx * wy0) * longint'(signed'(scalar_mem[j0*MAX_COLS + i0 + 1]));
        acc += (fx * fy) * longint'(signed'(scalar_mem[(j0+1)*MAX_COLS + i0 + 1]));
        res.value = VALW'(acc >>> 32);
        res.in_range = 1'b1;
        return res;
    endfunction

    function automatic void store_load(logic [1:0] op, int unsigned c, int unsigned r,
                                       logic [31:0] v);
        case (op)
            OP_LOAD_SC: if (c < MAX_COLS && r < MAX_ROWS) begin
                scalar_mem[r*MAX_COLS + c] = v;
                scalar_set[r*MAX_COLS + c] = 1'b1;
            end
            OP_LOAD_XV: if (c <= MAX_COLS && r < MAX_ROWS) begin
                xvel_mem[r*XV_STRIDE + c] = v;
                xvel_set[r*XV_STRIDE + c] = 1'b1;
            end
            OP_LOAD_YV: if (c < MAX_COLS && r <= MAX_ROWS) begin
                yvel_mem[r*MAX_COLS + c] = v;
                yvel_set[r*MAX_COLS + c] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Mostly velocities of a few cells per step, now and then any word at all.
    function automatic logic [31:0] rand_velocity();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 6 << 16) - (3 << 16);
    endfunction

    task automatic send_beat(logic [1:0] op, int unsigned c, int unsigned r,
                             logic [31:0] v, bit typed = 0, logic [31:0] typed_val = '0);
        int gap;
        bit accepted;
        t_advect_res res;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_col <= IDXW'(c);
        i_row <= IDXW'(r);
        i_value <= v;
        do begin
            @(negedge i_clk);
            accepted = !o_stall;
            @(posedge i_clk);
        end while (!accepted);
        beats_sent++;
        if (op == OP_COMPUTE) begin
            res = advect_cell(c, r);
            if (typed) begin
                res.value = typed_val;
                res.in_range = 1'b0;
            end
            pending_results.push_back(res);
        end else begin
            store_load(op, c, r, v);
        end
    endtask

    // Loads whatever entries the compute will read and that were never written.
    task automatic compute_cell(int unsigned c, int unsigned r);
        int unsigned i0, j0;
        longint fx, fy;
        if (cell_interior(c, r)) begin
            if (!xvel_set[r*XV_STRIDE + c]) send_beat(OP_LOAD_XV, c, r, rand_velocity());
            if (!xvel_set[r*XV_STRIDE + c + 1])
                send_beat(OP_LOAD_XV, c + 1, r, rand_velocity());
            if (!yvel_set[r*MAX_COLS + c]) send_beat(OP_LOAD_YV, c, r, rand_velocity());
            if (!yvel_set[(r+1)*MAX_COLS + c])
                send_beat(OP_LOAD_YV, c, r + 1, rand_velocity());
            source_point(c, r, i0, j0, fx, fy);
            for (int dj = 0; dj < 2; dj++) begin
                for (int di = 0; di < 2; di++) begin
                    if (!scalar_set[(j0+dj)*MAX_COLS + i0 + di])
                        send_beat(OP_LOAD_SC, i0 + di, j0 + dj, $urandom);
                end
            end
        end
        send_beat(OP_COMPUTE, c, r, $urandom);
    endtask

    task automatic write_cfg(logic [CFGIW-1:0] idx, logic [CFGW-1:0] data);
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  grid_w = data[7:0];
            CFG_GRID_HEIGHT: grid_h = data[7:0];
            CFG_STEP_RATIO:  step_r = data[23:0];
            default: ;
        endcase
    endtask

    // Result side: a random hold before each beat, or a long one on request.
    initial begin
        int hold;
        bit seen;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold = 200;
            end else begin
                hold = rx_quiet ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                seen = o_valid;
                @(posedge i_clk);
            end while (!seen);
        end
    end

    // Inputs only change at rising edges, so the state at the falling edge
    // is what the next rising edge takes.
    always @(negedge i_clk) begin
        t_advect_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: col %0d row %0d value %h",
                             o_out_col, o_out_row, o_result_value);
            end else begin
                want = pending_results.pop_front();
                if (o_result_value !== want.value || o_in_range !== want.in_range ||
                    o_out_col !== want.col || o_out_row !== want.row) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result differs: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                                 want.value, want.in_range, want.col, want.row,
                                 o_result_value, o_in_range, o_out_col, o_out_row);
                end
            end
        end
    end

    initial begin
        t_dir_row dir_rows [$];
        int unsigned w, h, c, r, kind;
        int drain;
        mismatches = 0;
        beats_sent = 0;
        tx_quiet = 0;
        rx_quiet = 0;
        rx_hold_req = 0;
        grid_w = GRID_WIDTH_RST;
        grid_h = GRID_HEIGHT_RST;
        step_r = STEP_RATIO_RST;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_LOAD_SC;
        i_col = '0;
        i_row = '0;
        i_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_GRID_WIDTH;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Border cells give zero with in_range low; stray loads are dropped.
        dir_rows = '{
            '{OP_COMPUTE, 0, 0, 32'h0, 1, 32'h0},
            '{OP_COMPUTE, 127, 1, 32'h0, 1, 32'h0},
            '{OP_COMPUTE, 1, 127, 32'hFFFFFFFF, 1, 32'h0},
            '{OP_COMPUTE, 255, 255, 32'h0, 1, 32'h0},
            '{OP_LOAD_SC, 255, 255, 32'h7FFFFFFF, 0, 32'h0},
            '{OP_LOAD_SC, 128, 0, 32'h12345678, 0, 32'h0},
            '{OP_LOAD_XV, 129, 0, 32'h7FFFFFFF, 0, 32'h0},
            '{OP_LOAD_YV, 0, 129, 32'h80000000, 0, 32'h0},
            '{OP_LOAD_XV, 128, 127, 32'h80000000, 0, 32'h0},
            '{OP_LOAD_YV, 127, 128, 32'hFFFFFFFF, 0, 32'h0},
            '{OP_LOAD_SC, 127, 127, 32'h80000000, 0, 32'h0},
            '{OP_LOAD_SC, 0, 0, 32'h7FFFFFFF, 0, 32'h0},
            '{OP_COMPUTE, 1, 1, 32'h0, 0, 32'h0},
            '{OP_COMPUTE, 126, 126, 32'h0, 0, 32'h0},
            '{OP_LOAD_XV, 64, 64, 32'h7FFFFFFF, 0, 32'h0},
            '{OP_LOAD_XV, 65, 64, 32'h7FFFFFFF, 0, 32'h0},
            '{OP_COMPUTE, 64, 64, 32'h0, 0, 32'h0},
            '{OP_LOAD_XV, 64, 64, 32'h80000000, 0, 32'h0},
            '{OP_LOAD_XV, 65, 64, 32'h80000000, 0, 32'h0},
            '{OP_LOAD_YV, 64, 64, 32'h80000000, 0, 32'h0},
            '{OP_LOAD_YV, 64, 65, 32'h80000000, 0, 32'h0},
            '{OP_COMPUTE, 64, 64, 32'h0, 0, 32'h0}
        };
        foreach (dir_rows[k]) begin
            if (dir_rows[k].op == OP_COMPUTE && !dir_rows[k].typed)
                compute_cell(dir_rows[k].col, dir_rows[k].row);
            else
                send_beat(dir_rows[k].op, dir_rows[k].col, dir_rows[k].row,
                          dir_rows[k].value, dir_rows[k].typed, dir_rows[k].exp_value);
        end

        // Out-of-range and limit sizes first, then random settings, mostly small grids.
        for (int phase = 0; beats_sent < 1550; phase++) begin
            case (phase)
                0: begin w = 0; h = 2; end
                1: begin w = 255; h = 255; end
                2: begin w = 128; h = 3; end
                default: begin
                    w = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 255)
                                                    : $urandom_range(3, 16);
                    h = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 255)
                                                    : $urandom_range(3, 16);
                end
            endcase
            write_cfg(CFG_GRID_WIDTH, CFGW'(w));
            write_cfg(CFG_GRID_HEIGHT, CFGW'(h));
            case (phase % 4)
                0: write_cfg(CFG_STEP_RATIO, 24'h0);
                1: write_cfg(CFG_STEP_RATIO, 24'hFFFFFF);
                default: write_cfg(CFG_STEP_RATIO, CFGW'($urandom_range(0, 24'h03FFFF)));
            endcase
            if (phase == 3) write_cfg(CFG_UNUSED, 24'hFFFFFF);
            tx_quiet = $urandom_range(0, 3) == 0;
            rx_quiet = $urandom_range(0, 3) == 0;
            if (phase == 4) begin
                tx_quiet = 1;
                rx_hold_req = 1;
            end
            w = eff_size(grid_w);
            h = eff_size(grid_h);
            for (int n = 0; n < 80 && beats_sent < 1550; n++) begin
                kind = $urandom_range(0, 9);
                if (n == 40 && phase == 5) begin
                    i_valid <= 1'b0;
                    wait (pending_results.size() == 0);
                    @(posedge i_clk);
                end
                if (kind < 6) begin
                    compute_cell($urandom_range(1, w - 2), $urandom_range(1, h - 2));
                end else if (kind == 6) begin
                    compute_cell($urandom_range(0, 255), $urandom_range(0, 255));
                end else if (kind == 7) begin
                    c = $urandom_range(0, w);
                    r = $urandom_range(0, h);
                    send_beat(2'($urandom_range(OP_LOAD_SC, OP_LOAD_YV)), c, r,
                              $urandom_range(0, 1) ? $urandom : rand_velocity());
                end else begin
                    send_beat(2'($urandom_range(OP_LOAD_SC, OP_LOAD_YV)),
                              $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
                end
            end
        end

        i_valid <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (LATENCY_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hw/rtl/sla_pkg.sv
hw/rtl/sla_trace.sv
hw/rtl/sla_blend.sv
hw/rtl/scalar_semi_lagrangian_advect_unit.sv
hw/rtl/sla_check.sv
tb/tb_top.sv
